FILE: hdl/point_in_polygon_crossing_unit_assert.svh
// ----------------------------------------------------------------------------
// point-in-polygon crossing unit: assertion macros
// shared property forms used by the rtl checks
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CROSSING_UNIT_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_UNIT_ASSERT_SVH

// antecedent in a cycle implies consequent in the same cycle
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold at a clock edge out of reset
`define PIP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// shared types for the point-in-polygon crossing unit
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  // flags that travel with one edge from front to back
  typedef struct packed {
    logic test;   // edge straddles the point's y
    logic down;   // edge start y below edge end y
    logic fin;    // closing edge of the polygon, result follows
    logic few;    // polygon had two or fewer vertices
  } pip_ctl_t;

  // front status seen by the top level
  typedef struct packed {
    logic close_pend;  // closing edge waiting for queue space
    logic mid_poly;    // at least one vertex of a polygon taken
  } pip_fst_t;

endpackage

`default_nettype wire

FILE: hdl/pip_vtx_if.sv
// ----------------------------------------------------------------------------
// pip_vtx_if
// vertex channel: valid/ready with one polygon vertex per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_vtx_if #(
  parameter int COORD_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

`default_nettype wire

FILE: hdl/pip_res_if.sv
// ----------------------------------------------------------------------------
// pip_res_if
// result channel: valid/ready with one verdict per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_res_if ();
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few;

  modport source (output valid, inside_res, too_few, input ready);
  modport sink   (input valid, inside_res, too_few, output ready);
endinterface

`default_nettype wire

FILE: hdl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// takes vertices, tracks first/previous vertex and issues edge jobs
// ----------------------------------------------------------------------------
`default_nettype none

module pip_front #(
  parameter int COORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_BITS-1:0]     vertex_x,
  input  logic signed [COORD_BITS-1:0]     vertex_y,
  input  logic                             last_vertex,
  input  logic signed [COORD_BITS-1:0]     point_x,
  input  logic signed [COORD_BITS-1:0]     point_y,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [4*(COORD_BITS+1)-1:0]      q_ops,
  output pip_pkg::pip_ctl_t                q_ctl,
  output pip_pkg::pip_fst_t                status
);
  import pip_pkg::*;

  localparam int D = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [1:0]                   seen_r, seen_nxt;
  logic                         close_pend_r, close_few_r;
  logic                         accept;
  logic signed [COORD_BITS-1:0] ix, iy, jx, jy;
  logic signed [D-1:0]          ax, ay, bx, by;

  assign in_ready = !close_pend_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign seen_nxt = (seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1;

  // edge end points: closing edge, degenerate single vertex, or cur/prev
  always_comb begin
    if (close_pend_r) begin
      ix = first_x_r; iy = first_y_r; jx = prev_x_r; jy = prev_y_r;
    end else if (seen_r == 2'd0) begin
      ix = vertex_x; iy = vertex_y; jx = vertex_x; jy = vertex_y;
    end else begin
      ix = vertex_x; iy = vertex_y; jx = prev_x_r; jy = prev_y_r;
    end
  end

  assign ax = D'(ix) - D'(point_x);
  assign ay = D'(iy) - D'(point_y);
  assign bx = D'(jx) - D'(point_x);
  assign by = D'(jy) - D'(point_y);

  assign q_ops = {ax, ay, bx, by};
  assign q_push = close_pend_r ? !q_full
                               : (accept && ((seen_r != 2'd0) || last_vertex));

  always_comb begin
    q_ctl.test = (iy > point_y) != (jy > point_y);
    q_ctl.down = iy < jy;
    q_ctl.fin  = close_pend_r || ((seen_r == 2'd0) && last_vertex);
    q_ctl.few  = close_pend_r ? close_few_r : 1'b1;
  end

  assign status.close_pend = close_pend_r;
  assign status.mid_poly   = seen_r != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 2'd0;
      close_pend_r <= 1'b0;
      close_few_r  <= 1'b0;
    end else if (close_pend_r) begin
      if (!q_full) begin
        close_pend_r <= 1'b0;
        seen_r       <= 2'd0;
      end
    end else if (accept) begin
      if (last_vertex) begin
        if (seen_r != 2'd0) begin
          close_pend_r <= 1'b1;
          close_few_r  <= seen_r == 2'd1;
        end
      end else begin
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !close_pend_r) begin
      if (seen_r == 2'd0) begin
        first_x_r <= vertex_x;
        first_y_r <= vertex_y;
      end
      prev_x_r <= vertex_x;
      prev_y_r <= vertex_y;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pip_queue.sv
// ----------------------------------------------------------------------------
// pip_queue
// small synchronous fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module pip_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back
// exact cross-product sign per edge, crossing parity and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pip_back #(
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  logic [4*(COORD_BITS+1)-1:0] q_ops,
  input  pip_pkg::pip_ctl_t           q_ctl,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        inside_res,
  output logic                        too_few
);
  import pip_pkg::*;

  localparam int D  = COORD_BITS + 1;
  localparam int L  = (D + 1) / 2;
  localparam int H  = D - L;
  localparam int P2 = 2 * D;

  logic signed [D-1:0] ax, ay, bx, by;
  logic                adv;

  // stage 1: partial products of ax*by and ay*bx
  logic signed [2*H-1:0] hh_p, hh_q, hh_p_r, hh_q_r;
  logic signed [H+L:0]   hl_p, lh_p, hl_q, lh_q, hl_p_r, lh_p_r, hl_q_r, lh_q_r;
  logic [2*L-1:0]        ll_p, ll_q, ll_p_r, ll_q_r;
  pip_ctl_t              s1_ctl_r, s2_ctl_r;
  logic                  s1_v_r, s2_v_r;

  // stage 2: full products
  logic signed [P2-1:0]  p_sum, q_sum, p_r, q_r;

  // stage 3: difference sign and verdict
  logic signed [P2:0]    diff;
  logic                  d_neg, d_pos, hit;
  logic                  parity_r, out_valid_r, inside_r, few_r;

  assign {ax, ay, bx, by} = q_ops;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  always_comb begin
    hh_p = $signed(ax[D-1:L]) * $signed(by[D-1:L]);
    hl_p = $signed(ax[D-1:L]) * $signed({1'b0, by[L-1:0]});
    lh_p = $signed({1'b0, ax[L-1:0]}) * $signed(by[D-1:L]);
    ll_p = ax[L-1:0] * by[L-1:0];
    hh_q = $signed(ay[D-1:L]) * $signed(bx[D-1:L]);
    hl_q = $signed(ay[D-1:L]) * $signed({1'b0, bx[L-1:0]});
    lh_q = $signed({1'b0, ay[L-1:0]}) * $signed(bx[D-1:L]);
    ll_q = ay[L-1:0] * bx[L-1:0];
  end

  assign p_sum = (P2'(hh_p_r) <<< (2 * L)) + ((P2'(hl_p_r) + P2'(lh_p_r)) <<< L)
               + P2'(ll_p_r);
  assign q_sum = (P2'(hh_q_r) <<< (2 * L)) + ((P2'(hl_q_r) + P2'(lh_q_r)) <<< L)
               + P2'(ll_q_r);

  assign diff  = (P2 + 1)'(p_r) - (P2 + 1)'(q_r);
  assign d_neg = diff[P2];
  assign d_pos = !d_neg && (diff != '0);
  assign hit   = s2_ctl_r.test && (s2_ctl_r.down ? d_pos : d_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= q_valid;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r && s2_ctl_r.fin;
      if (s2_v_r) begin
        parity_r <= s2_ctl_r.fin ? 1'b0 : (parity_r ^ hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hh_p_r   <= hh_p;   hl_p_r <= hl_p;   lh_p_r <= lh_p;   ll_p_r <= ll_p;
      hh_q_r   <= hh_q;   hl_q_r <= hl_q;   lh_q_r <= lh_q;   ll_q_r <= ll_q;
      s1_ctl_r <= q_ctl;
      p_r      <= p_sum;
      q_r      <= q_sum;
      s2_ctl_r <= s1_ctl_r;
      if (s2_v_r && s2_ctl_r.fin) begin
        inside_r <= !s2_ctl_r.few && (parity_r ^ hit);
        few_r    <= s2_ctl_r.few;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign inside_res = inside_r;
  assign too_few    = few_r;

endmodule

`default_nettype wire

FILE: hdl/point_in_polygon_crossing_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_unit
// even-odd crossing test of a configured point against a streamed polygon
// ----------------------------------------------------------------------------
//
//   port       direction  carries                            transfer
//   in_vtx     sink       vertex_x, vertex_y, last_vertex    valid & ready
//   out_res    source     inside_res, too_few                valid & ready
//   apb (psel) slave      point_x @ 0, point_y @ stride      psel & penable
//
// one vertex per cycle while the edge queue has space and no closing edge
// is pending; the last vertex of a polygon with two or more vertices also
// holds the input for the closing edge, as the front issues its own edge
// and the closing edge through one queue port
// a result passes two multiply/sum stages, then the output register
// a stalled result only holds the back; the front keeps taking vertices
// until the edge queue fills
// synchronous active-low reset, no clearing pass
//
`default_nettype none
`include "point_in_polygon_crossing_unit_assert.svh"

module point_in_polygon_crossing_unit #(
  parameter int COORD_BITS  = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  pip_vtx_if.sink   in_vtx,
  pip_res_if.source out_res,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [((COORD_BITS > 32) ? 4 : 3)-1:0]     paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0]   pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0]   prdata,
  output logic                                       pready
);
  import pip_pkg::*;

  localparam int DATA_W  = (COORD_BITS > 32) ? 64 : 32;
  localparam int ADDR_W  = (COORD_BITS > 32) ? 4 : 3;
  localparam int IDX_LSB = (COORD_BITS > 32) ? 3 : 2;
  localparam int IDX_W   = ADDR_W - IDX_LSB;
  localparam int D       = COORD_BITS + 1;
  localparam int Q_W     = 4 * D + $bits(pip_ctl_t);

  localparam logic [IDX_W-1:0] REG_POINT_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_POINT_Y = IDX_W'(1);

  // configuration registers
  logic signed [COORD_BITS-1:0] point_x_r, point_y_r;
  logic [IDX_W-1:0]             reg_idx;
  logic                         reg_wr;

  // front to queue, queue to back
  logic                 q_push, q_pop, q_full, q_empty;
  logic [4*D-1:0]       f_ops, b_ops;
  pip_ctl_t             f_ctl, b_ctl;
  pip_fst_t             f_st;

  assign reg_idx = paddr[ADDR_W-1:IDX_LSB];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register write, sign bits above the coordinate width dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_x_r <= '0;
      point_y_r <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_POINT_X: point_x_r <= pwdata[COORD_BITS-1:0];
        REG_POINT_Y: point_y_r <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back sign extended to the bus width
  always_comb begin
    unique case (reg_idx)
      REG_POINT_X: prdata = DATA_W'(point_x_r);
      REG_POINT_Y: prdata = DATA_W'(point_y_r);
      default:     prdata = '0;
    endcase
  end

  // front: vertex bookkeeping and edge issue
  pip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_vtx.valid),
    .in_ready    (in_vtx.ready),
    .vertex_x    (in_vtx.vertex_x),
    .vertex_y    (in_vtx.vertex_y),
    .last_vertex (in_vtx.last_vertex),
    .point_x     (point_x_r),
    .point_y     (point_y_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ops       (f_ops),
    .q_ctl       (f_ctl),
    .status      (f_st)
  );

  // edge queue decouples the two sides
  pip_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({f_ctl, f_ops}),
    .pop     (q_pop),
    .rd_data ({b_ctl, b_ops}),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: exact edge test, parity and result register
  pip_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_ops      (b_ops),
    .q_ctl      (b_ctl),
    .q_pop      (q_pop),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .inside_res (out_res.inside_res),
    .too_few    (out_res.too_few)
  );

  // checks
  `PIP_ASSERT_NEVER(a_no_push_full, q_push && q_full, "edge pushed into full queue")
  `PIP_ASSERT_NEVER(a_no_pop_empty, q_pop && q_empty, "edge popped from empty queue")
  `PIP_ASSERT_IMP(a_close_blocks, f_st.close_pend, !in_vtx.ready && f_st.mid_poly, "vertex taken while closing edge pending")
  `PIP_ASSERT_IMP(a_few_outside, out_res.valid && out_res.too_few, !out_res.inside_res, "too-few polygon reported inside")

endmodule

`default_nettype wire
